>>> src/tdc_pkg.sv
// ----------------------------------------------------------------------------
// tdc_pkg
// Types, codes and time arithmetic shared by the time-of-day counter.
// ----------------------------------------------------------------------------
`default_nettype none

package tdc_pkg;

    localparam int HOURS_PER_DAY = 24;
    localparam int MIN_PER_HOUR  = 60;
    localparam int SEC_PER_MIN   = 60;
    localparam int SEC_PER_HOUR  = 3600;
    localparam int MIN_PER_DAY   = 1440;
    localparam int SEC_PER_DAY   = 86400;
    localparam int MAX_HOUR      = 23;
    localparam int MAX_MINUTE    = 59;
    localparam int MAX_SECOND    = 59;
    localparam int NOON          = 12;

    // Request codes.
    localparam logic [2:0] REQ_SET     = 3'd0;
    localparam logic [2:0] REQ_ADD_HR  = 3'd1;
    localparam logic [2:0] REQ_SUB_HR  = 3'd2;
    localparam logic [2:0] REQ_ADD_MIN = 3'd3;
    localparam logic [2:0] REQ_SUB_MIN = 3'd4;
    localparam logic [2:0] REQ_ADD_SEC = 3'd5;
    localparam logic [2:0] REQ_SUB_SEC = 3'd6;
    localparam logic [2:0] REQ_READ    = 3'd7;

    // Set formats.
    localparam logic [1:0] FMT_24  = 2'd0;
    localparam logic [1:0] FMT_AM  = 2'd1;
    localparam logic [1:0] FMT_PM  = 2'd2;
    localparam logic [1:0] FMT_BAD = 2'd3;

    // Unit that an amount counts in.
    localparam logic [1:0] UNIT_NONE = 2'd0;
    localparam logic [1:0] UNIT_HR   = 2'd1;
    localparam logic [1:0] UNIT_MIN  = 2'd2;
    localparam logic [1:0] UNIT_SEC  = 2'd3;

    typedef struct packed {
        logic [4:0] hh;
        logic [5:0] mm;
        logic [5:0] ss;
    } t_hms;

    typedef struct packed {
        logic [2:0] op;
        t_hms       set_time;
        logic       set_bad;
        logic       set_twelve;
    } t_req;

    // Sum of two times of day, wrapping over midnight.
    function automatic t_hms hms_add(input t_hms a, input t_hms b);
        logic [6:0] s_sum;
        logic [6:0] m_sum;
        logic [5:0] h_sum;
        logic       c_s;
        logic       c_m;
        t_hms       res;
        s_sum = {1'b0, a.ss} + {1'b0, b.ss};
        c_s   = (s_sum >= 7'(SEC_PER_MIN));
        if (c_s) begin
            s_sum = s_sum - 7'(SEC_PER_MIN);
        end
        m_sum = {1'b0, a.mm} + {1'b0, b.mm} + {6'd0, c_s};
        c_m   = (m_sum >= 7'(MIN_PER_HOUR));
        if (c_m) begin
            m_sum = m_sum - 7'(MIN_PER_HOUR);
        end
        h_sum = {1'b0, a.hh} + {1'b0, b.hh} + {5'd0, c_m};
        if (h_sum >= 6'(HOURS_PER_DAY)) begin
            h_sum = h_sum - 6'(HOURS_PER_DAY);
        end
        res.ss = s_sum[5:0];
        res.mm = m_sum[5:0];
        res.hh = h_sum[4:0];
        return res;
    endfunction

    // Difference a - b of two times of day, wrapping back over midnight.
    function automatic t_hms hms_sub(input t_hms a, input t_hms b);
        logic [6:0] s_dif;
        logic [6:0] m_dif;
        logic [5:0] h_dif;
        logic       b_s;
        logic       b_m;
        t_hms       res;
        s_dif = {1'b0, a.ss} - {1'b0, b.ss};
        b_s   = s_dif[6];
        if (b_s) begin
            s_dif = s_dif + 7'(SEC_PER_MIN);
        end
        m_dif = {1'b0, a.mm} - {1'b0, b.mm} - {6'd0, b_s};
        b_m   = m_dif[6];
        if (b_m) begin
            m_dif = m_dif + 7'(MIN_PER_HOUR);
        end
        h_dif = {1'b0, a.hh} - {1'b0, b.hh} - {5'd0, b_m};
        if (h_dif[5]) begin
            h_dif = h_dif + 6'(HOURS_PER_DAY);
        end
        res.ss = s_dif[5:0];
        res.mm = m_dif[5:0];
        res.hh = h_dif[4:0];
        return res;
    endfunction

    // Weight of amount bit k in the given unit, reduced over one day.
    // Only called with constant arguments. One is already below every
    // period, so the doubling starts from it; the split into digits is done
    // by repeated subtraction.
    function automatic t_hms hms_pow2(input int k, input logic [1:0] unit);
        int   r;
        int   period;
        int   q;
        t_hms res;
        r   = 1;
        q   = 0;
        res = '0;
        case (unit)
            UNIT_HR:  period = HOURS_PER_DAY;
            UNIT_MIN: period = MIN_PER_DAY;
            default:  period = SEC_PER_DAY;
        endcase
        for (int n = 0; n < k; n++) begin
            r = r * 2;
            if (r >= period) begin
                r = r - period;
            end
        end
        case (unit)
            UNIT_HR: begin
                res.hh = 5'(r);
            end
            UNIT_MIN: begin
                while (r >= MIN_PER_HOUR) begin
                    r = r - MIN_PER_HOUR;
                    q = q + 1;
                end
                res.hh = 5'(q);
                res.mm = 6'(r);
            end
            default: begin
                while (r >= SEC_PER_HOUR) begin
                    r = r - SEC_PER_HOUR;
                    q = q + 1;
                end
                res.hh = 5'(q);
                q      = 0;
                while (r >= SEC_PER_MIN) begin
                    r = r - SEC_PER_MIN;
                    q = q + 1;
                end
                res.mm = 6'(q);
                res.ss = 6'(r);
            end
        endcase
        return res;
    endfunction

endpackage

`default_nettype wire

>>> src/tdc_amount_tree.sv
// ----------------------------------------------------------------------------
// tdc_amount_tree
// Registers a request and reduces its amount to a time-of-day offset
// through a pipelined binary adder tree, one tree level per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module tdc_amount_tree
    import tdc_pkg::*;
#(
    parameter int AMOUNT_WIDTH = 16
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_valid,
    output logic                         o_ready,
    input  wire logic [2:0]              i_req_type,
    input  wire logic [AMOUNT_WIDTH-1:0] i_amount,
    input  wire logic [4:0]              i_set_hour,
    input  wire logic [5:0]              i_set_minute,
    input  wire logic [5:0]              i_set_second,
    input  wire logic [1:0]              i_set_format,
    output logic                         o_valid,
    input  wire logic                    i_ready,
    output t_req                         o_req,
    output t_hms                         o_delta
);

    localparam int LEVELS = (AMOUNT_WIDTH > 1) ? $clog2(AMOUNT_WIDTH) : 0;
    localparam int NLEAF  = 1 << LEVELS;
    localparam int NNODE  = 2 * NLEAF;

    // Tree nodes in heap order: node 1 is the root, leaves start at NLEAF.
    t_hms [NNODE-1:1]  r_node;
    t_hms [NNODE-1:1]  n_node;
    t_req [LEVELS:0]   r_req;
    t_req [LEVELS:0]   n_req;
    logic [LEVELS:0]   r_vld;
    logic [LEVELS:0]   n_vld;
    logic [LEVELS+1:0] w_rdy;
    logic [LEVELS:0]   w_ld;
    t_hms [NLEAF-1:0]  w_leaf;
    logic [1:0]        w_unit;
    t_req              w_in_req;

    always_comb begin
        case (i_req_type) inside
            REQ_ADD_HR, REQ_SUB_HR:   w_unit = UNIT_HR;
            REQ_ADD_MIN, REQ_SUB_MIN: w_unit = UNIT_MIN;
            REQ_ADD_SEC, REQ_SUB_SEC: w_unit = UNIT_SEC;
            default:                  w_unit = UNIT_NONE;
        endcase
    end

    // Set requests are checked and converted to 24-hour form on entry.
    always_comb begin
        w_in_req.op          = i_req_type;
        w_in_req.set_bad     = (i_set_format == FMT_BAD)
                            || (i_set_hour > 5'(MAX_HOUR))
                            || (i_set_minute > 6'(MAX_MINUTE))
                            || (i_set_second > 6'(MAX_SECOND))
                            || ((i_set_format == FMT_AM) && (i_set_hour > 5'(NOON)));
        w_in_req.set_twelve  = (i_set_format != FMT_24);
        w_in_req.set_time.mm = i_set_minute;
        w_in_req.set_time.ss = i_set_second;
        if ((i_set_format == FMT_PM) && (i_set_hour < 5'(NOON))) begin
            w_in_req.set_time.hh = i_set_hour + 5'(NOON);
        end else begin
            w_in_req.set_time.hh = i_set_hour;
        end
    end

    // Each stage loads when it is empty or its successor moves on.
    always_comb begin
        w_rdy[LEVELS+1] = i_ready;
        for (int s = LEVELS; s >= 0; s--) begin
            w_rdy[s] = !r_vld[s] || w_rdy[s+1];
        end
        w_ld[0]  = w_rdy[0] && i_valid;
        n_vld[0] = w_rdy[0] ? i_valid : r_vld[0];
        n_req[0] = w_ld[0] ? w_in_req : r_req[0];
        for (int s = 1; s <= LEVELS; s++) begin
            w_ld[s]  = w_rdy[s] && r_vld[s-1];
            n_vld[s] = w_rdy[s] ? r_vld[s-1] : r_vld[s];
            n_req[s] = w_ld[s] ? r_req[s-1] : r_req[s];
        end
    end

    for (genvar i = 0; i < NLEAF; i++) begin : g_leaf
        if (i < AMOUNT_WIDTH) begin : g_bit
            localparam t_hms K_HR  = hms_pow2(i, UNIT_HR);
            localparam t_hms K_MIN = hms_pow2(i, UNIT_MIN);
            localparam t_hms K_SEC = hms_pow2(i, UNIT_SEC);
            always_comb begin
                if (!i_amount[i]) begin
                    w_leaf[i] = '0;
                end else begin
                    case (w_unit)
                        UNIT_HR:  w_leaf[i] = K_HR;
                        UNIT_MIN: w_leaf[i] = K_MIN;
                        UNIT_SEC: w_leaf[i] = K_SEC;
                        default:  w_leaf[i] = '0;
                    endcase
                end
            end
        end else begin : g_pad
            assign w_leaf[i] = '0;
        end
        assign n_node[NLEAF+i] = w_ld[0] ? w_leaf[i] : r_node[NLEAF+i];
    end

    for (genvar j = 1; j < NLEAF; j++) begin : g_node
        localparam int STG = LEVELS - ($clog2(j + 1) - 1);
        assign n_node[j] = w_ld[STG] ? hms_add(r_node[2*j], r_node[2*j+1]) : r_node[j];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_node <= n_node;
        r_req  <= n_req;
    end

    assign o_ready = w_rdy[0];
    assign o_valid = r_vld[LEVELS];
    assign o_req   = r_req[LEVELS];
    assign o_delta = r_node[1];

endmodule

`default_nettype wire

>>> src/tdc_clock_core.sv
// ----------------------------------------------------------------------------
// tdc_clock_core
// Holds the time of day and mode flags, applies one request per cycle unless
// the result stalls, and presents the new time as the registered result.
// ----------------------------------------------------------------------------
`default_nettype none

module tdc_clock_core
    import tdc_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_ready,
    input  wire t_req i_req,
    input  wire t_hms i_delta,
    output logic      o_valid,
    input  wire logic i_stall,
    output logic [4:0] o_hour_24,
    output logic [4:0] o_hour_display,
    output logic [5:0] o_minute_now,
    output logic [5:0] o_second_now,
    output logic      o_is_pm,
    output logic      o_twelve_hour,
    output logic      o_error
);

    t_hms r_time;
    t_hms n_time;
    logic r_twelve;
    logic n_twelve;
    logic r_error;
    logic n_error;
    logic r_out_vld;
    logic w_take;

    assign o_ready = !r_out_vld || !i_stall;
    assign w_take  = o_ready && i_valid;

    always_comb begin
        n_time   = r_time;
        n_twelve = r_twelve;
        n_error  = r_error;
        case (i_req.op) inside
            REQ_SET: begin
                if (i_req.set_bad) begin
                    n_time  = '0;
                    n_error = 1'b1;
                end else begin
                    n_time   = i_req.set_time;
                    n_twelve = i_req.set_twelve;
                    n_error  = 1'b0;
                end
            end
            REQ_ADD_HR, REQ_ADD_MIN, REQ_ADD_SEC: n_time = hms_add(r_time, i_delta);
            REQ_SUB_HR, REQ_SUB_MIN, REQ_SUB_SEC: n_time = hms_sub(r_time, i_delta);
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time    <= '0;
            r_twelve  <= 1'b0;
            r_error   <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (o_ready) begin
                r_out_vld <= i_valid;
            end
            if (w_take) begin
                r_time   <= n_time;
                r_twelve <= n_twelve;
                r_error  <= n_error;
            end
        end
    end

    assign o_valid        = r_out_vld;
    assign o_hour_24      = r_time.hh;
    assign o_hour_display = (r_twelve && (r_time.hh > 5'(NOON))) ? r_time.hh - 5'(NOON)
                                                                 : r_time.hh;
    assign o_minute_now   = r_time.mm;
    assign o_second_now   = r_time.ss;
    assign o_is_pm        = (r_time.hh >= 5'(NOON));
    assign o_twelve_hour  = r_twelve;
    assign o_error        = r_error;

endmodule

`default_nettype wire

>>> src/time_of_day_counter.sv
// ----------------------------------------------------------------------------
// time_of_day_counter
// Pipeline: a request passes the request register, the adder-tree level
// registers and the result register in the clock core.
// Throughput: one request per cycle unless the result side stalls; the
// clock core updates its hours/minutes/seconds register once per request.
// Reset: synchronous, active low; clears the time to 00:00:00, selects
// 24-hour mode, clears the error flag and empties the pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

// The block keeps a time of day as hours, minutes and seconds. Each request
// (set, add or subtract in some unit, or read) yields exactly one result
// transaction carrying the time after the request.
//
// The amount of an add or subtract request does not depend on the current
// time, so it is reduced ahead of time: every amount bit selects a constant
// offset (its weight in the request's unit, taken modulo one day) and a
// pipelined adder tree sums these offsets into one hh:mm:ss offset. The clock
// core then only adds or subtracts that offset with a short carry chain of
// mod-60, mod-60 and mod-24 digits, which is what lets one request retire per
// cycle while the result side does not stall.
//
// Each pipeline stage takes a new transaction whenever it is empty or its
// successor moves on, so bubbles are filled and requests keep flowing into
// free stages while a finished result waits in the output register.
module time_of_day_counter
    import tdc_pkg::*;
#(
    parameter int AMOUNT_WIDTH = 16
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    // Request channel.
    input  wire logic                    i_valid,
    output logic                         o_stall,
    input  wire logic [2:0]              i_req_type,
    input  wire logic [AMOUNT_WIDTH-1:0] i_amount,
    input  wire logic [4:0]              i_set_hour,
    input  wire logic [5:0]              i_set_minute,
    input  wire logic [5:0]              i_set_second,
    input  wire logic [1:0]              i_set_format,
    // Result channel.
    output logic                         o_valid,
    input  wire logic                    i_stall,
    output logic [4:0]                   o_hour_24,
    output logic [4:0]                   o_hour_display,
    output logic [5:0]                   o_minute_now,
    output logic [5:0]                   o_second_now,
    output logic                         o_is_pm,
    output logic                         o_twelve_hour,
    output logic                         o_error
);

    logic tree_ready;
    logic tree_valid;
    logic core_ready;
    t_req tree_req;
    t_hms tree_delta;

    // Request register plus amount reduction tree.
    tdc_amount_tree #(
        .AMOUNT_WIDTH (AMOUNT_WIDTH)
    ) u_tree (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (tree_ready),
        .i_req_type   (i_req_type),
        .i_amount     (i_amount),
        .i_set_hour   (i_set_hour),
        .i_set_minute (i_set_minute),
        .i_set_second (i_set_second),
        .i_set_format (i_set_format),
        .o_valid      (tree_valid),
        .i_ready      (core_ready),
        .o_req        (tree_req),
        .o_delta      (tree_delta)
    );

    // Time register, mode flags and result register.
    tdc_clock_core u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (tree_valid),
        .o_ready        (core_ready),
        .i_req          (tree_req),
        .i_delta        (tree_delta),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_hour_24      (o_hour_24),
        .o_hour_display (o_hour_display),
        .o_minute_now   (o_minute_now),
        .o_second_now   (o_second_now),
        .o_is_pm        (o_is_pm),
        .o_twelve_hour  (o_twelve_hour),
        .o_error        (o_error)
    );

    // The request side is held off only when every stage is occupied and
    // the result register cannot drain.
    assign o_stall = !tree_ready;

endmodule

`default_nettype wire

>>> src/tdc_checker.sv
// ----------------------------------------------------------------------------
// tdc_port_checks
// Port-level checks on the time-of-day counter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module tdc_port_checks
    import tdc_pkg::*;
(
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       o_valid,
    input wire logic       i_stall,
    input wire logic [4:0] o_hour_24,
    input wire logic [4:0] o_hour_display,
    input wire logic [5:0] o_minute_now,
    input wire logic [5:0] o_second_now,
    input wire logic       o_is_pm,
    input wire logic       o_twelve_hour
);

    // No result is offered in the cycle after a reset.
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result offered right after reset");

    // A stalled result stays offered.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("result dropped while stalled");

    // Whenever a result is offered, its time is a legal time of day.
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_hour_24 <= 5'(MAX_HOUR)) && (o_minute_now <= 6'(MAX_MINUTE))
                    && (o_second_now <= 6'(MAX_SECOND)))
        else $error("time out of range");

    // Display hour and PM flag agree with the 24-hour value and the mode.
    a_display: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_is_pm == (o_hour_24 >= 5'(NOON)))
                    && (o_hour_display == ((o_twelve_hour && (o_hour_24 > 5'(NOON)))
                                           ? o_hour_24 - 5'(NOON) : o_hour_24)))
        else $error("display hour or PM flag inconsistent");

endmodule

bind time_of_day_counter tdc_port_checks u_tdc_port_checks (.*);

`default_nettype wire

>>> dv/tdc_checker.sv
// ----------------------------------------------------------------------------
// tdc_checker
// Predicts and checks every result transaction of the time-of-day counter.
// It watches the request and result channels, keeps its own copy of the
// clock state, and compares each result, field by field, with the oldest
// predicted reading.
// ----------------------------------------------------------------------------
module tdc_checker
    import tdc_pkg::*;
#(
    parameter int AMOUNT_WIDTH = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_req_valid,
    input  logic                    i_req_stall,
    input  logic [2:0]              i_req_type,
    input  logic [AMOUNT_WIDTH-1:0] i_amount,
    input  logic [4:0]              i_set_hour,
    input  logic [5:0]              i_set_minute,
    input  logic [5:0]              i_set_second,
    input  logic [1:0]              i_set_format,
    input  logic                    i_res_valid,
    input  logic                    i_res_stall,
    input  logic [4:0]              i_hour_24,
    input  logic [4:0]              i_hour_display,
    input  logic [5:0]              i_minute_now,
    input  logic [5:0]              i_second_now,
    input  logic                    i_is_pm,
    input  logic                    i_twelve_hour,
    input  logic                    i_error,
    output int                      o_fail_count,
    output int                      o_pending
);

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [4:0] hour_24;
        logic [4:0] hour_display;
        logic [5:0] minute_now;
        logic [5:0] second_now;
        logic       is_pm;
        logic       twelve_hour;
        logic       error;
    } t_tod_reading;

    t_tod_reading readings_due[$];
    int           mismatches = 0;

    // Shadow copy of the clock.
    int unsigned  cur_hour   = 0;
    int unsigned  cur_minute = 0;
    int unsigned  cur_second = 0;
    bit           mode_12    = 1'b0;
    bit           set_failed = 1'b0;

    assign o_fail_count = mismatches;

    // Moves a position on a cycle of the given length forward or back.
    function automatic int unsigned roll(input int unsigned pos, input int unsigned amt,
                                         input int unsigned span, input bit back);
        int unsigned step;
        step = amt % span;
        return back ? (pos + span - step) % span : (pos + step) % span;
    endfunction

    task automatic advance_clock(input logic [2:0] req, input logic [AMOUNT_WIDTH-1:0] amt,
                                 input logic [4:0] h, input logic [5:0] m,
                                 input logic [5:0] s, input logic [1:0] fmt,
                                 output t_tod_reading rd);
        int unsigned day_pos;
        bit          bad;
        case (req)
            REQ_SET: begin
                bad = (fmt == FMT_BAD) || (h > MAX_HOUR) || (m > MAX_MINUTE) ||
                      (s > MAX_SECOND) || (fmt == FMT_AM && h > NOON);
                if (bad) begin
                    cur_hour   = 0;
                    cur_minute = 0;
                    cur_second = 0;
                    set_failed = 1'b1;
                end else begin
                    cur_hour   = (fmt == FMT_PM && h < NOON) ? h + NOON : h;
                    cur_minute = m;
                    cur_second = s;
                    mode_12    = (fmt != FMT_24);
                    set_failed = 1'b0;
                end
            end
            REQ_ADD_HR, REQ_SUB_HR: begin
                cur_hour = roll(cur_hour, amt, HOURS_PER_DAY, req == REQ_SUB_HR);
            end
            REQ_ADD_MIN, REQ_SUB_MIN: begin
                day_pos    = roll(cur_hour * MIN_PER_HOUR + cur_minute, amt, MIN_PER_DAY,
                                  req == REQ_SUB_MIN);
                cur_hour   = day_pos / MIN_PER_HOUR;
                cur_minute = day_pos % MIN_PER_HOUR;
            end
            REQ_ADD_SEC, REQ_SUB_SEC: begin
                day_pos    = roll(cur_hour * SEC_PER_HOUR + cur_minute * SEC_PER_MIN +
                                  cur_second, amt, SEC_PER_DAY, req == REQ_SUB_SEC);
                cur_hour   = day_pos / SEC_PER_HOUR;
                cur_minute = (day_pos / SEC_PER_MIN) % MIN_PER_HOUR;
                cur_second = day_pos % SEC_PER_MIN;
            end
            default: begin
            end
        endcase
        rd.hour_24      = 5'(cur_hour);
        rd.hour_display = 5'((mode_12 && cur_hour > NOON) ? cur_hour - NOON : cur_hour);
        rd.minute_now   = 6'(cur_minute);
        rd.second_now   = 6'(cur_second);
        rd.is_pm        = (cur_hour >= NOON);
        rd.twelve_hour  = mode_12;
        rd.error        = set_failed;
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        t_tod_reading rd;
        if (!i_rst_n) begin
            cur_hour   = 0;
            cur_minute = 0;
            cur_second = 0;
            mode_12    = 1'b0;
            set_failed = 1'b0;
            readings_due.delete();
        end else begin
            if (i_req_valid && !i_req_stall) begin
                advance_clock(i_req_type, i_amount, i_set_hour, i_set_minute,
                              i_set_second, i_set_format, rd);
                readings_due.push_back(rd);
            end
            if (i_res_valid && !i_res_stall) begin
                if (readings_due.size() == 0) begin
                    $error("result transaction with no request outstanding");
                    mismatches++;
                end else begin
                    rd = readings_due.pop_front();
                    check_field("hour_24", rd.hour_24, i_hour_24);
                    check_field("hour_display", rd.hour_display, i_hour_display);
                    check_field("minute_now", rd.minute_now, i_minute_now);
                    check_field("second_now", rd.second_now, i_second_now);
                    check_field("is_pm", rd.is_pm, i_is_pm);
                    check_field("twelve_hour", rd.twelve_hour, i_twelve_hour);
                    check_field("error", rd.error, i_error);
                end
            end
        end
        o_pending <= readings_due.size();
    end

endmodule

>>> dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the time-of-day counter. A directed opening walks through
// midnight roll-over, noon, AM/PM loading and every kind of rejected set;
// a long random phase then mixes sets, adds, subtracts and reads with random
// idle gaps on the request side and random stalls on the result side. The
// checker beside the block predicts and compares every result transaction.
// ----------------------------------------------------------------------------
module tb_top
    import tdc_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int AMOUNT_WIDTH  = 16;
    // Settle time at the end, after every result has drained.
    localparam int SETTLE_CYCLES = 20;
    // Longest correct stretch without any transaction is the longest request
    // gap, the longest result stall and the pipeline delay; this is far above it.
    localparam int QUIET_LIMIT   = 1000;
    localparam int RANDOM_ITEMS  = 1650;

    logic                    i_clk          = 1'b0;
    logic                    i_rst_n        = 1'b0;
    logic                    i_valid        = 1'b0;
    logic                    o_stall;
    logic [2:0]              i_req_type     = REQ_READ;
    logic [AMOUNT_WIDTH-1:0] i_amount       = '0;
    logic [4:0]              i_set_hour     = '0;
    logic [5:0]              i_set_minute   = '0;
    logic [5:0]              i_set_second   = '0;
    logic [1:0]              i_set_format   = FMT_24;
    logic                    o_valid;
    logic                    i_stall        = 1'b0;
    logic [4:0]              o_hour_24;
    logic [4:0]              o_hour_display;
    logic [5:0]              o_minute_now;
    logic [5:0]              o_second_now;
    logic                    o_is_pm;
    logic                    o_twelve_hour;
    logic                    o_error;

    int                      fail_count;
    int                      readings_pending;
    int                      quiet_cycles   = 0;
    int                      tx_calm_left   = 0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    time_of_day_counter #(
        .AMOUNT_WIDTH(AMOUNT_WIDTH)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_req_type    (i_req_type),
        .i_amount      (i_amount),
        .i_set_hour    (i_set_hour),
        .i_set_minute  (i_set_minute),
        .i_set_second  (i_set_second),
        .i_set_format  (i_set_format),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_hour_24     (o_hour_24),
        .o_hour_display(o_hour_display),
        .o_minute_now  (o_minute_now),
        .o_second_now  (o_second_now),
        .o_is_pm       (o_is_pm),
        .o_twelve_hour (o_twelve_hour),
        .o_error       (o_error)
    );

    tdc_checker #(
        .AMOUNT_WIDTH(AMOUNT_WIDTH)
    ) checker_inst (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req_valid   (i_valid),
        .i_req_stall   (o_stall),
        .i_req_type    (i_req_type),
        .i_amount      (i_amount),
        .i_set_hour    (i_set_hour),
        .i_set_minute  (i_set_minute),
        .i_set_second  (i_set_second),
        .i_set_format  (i_set_format),
        .i_res_valid   (o_valid),
        .i_res_stall   (i_stall),
        .i_hour_24     (o_hour_24),
        .i_hour_display(o_hour_display),
        .i_minute_now  (o_minute_now),
        .i_second_now  (o_second_now),
        .i_is_pm       (o_is_pm),
        .i_twelve_hour (o_twelve_hour),
        .i_error       (o_error),
        .o_fail_count  (fail_count),
        .o_pending     (readings_pending)
    );

    // Presents one request transaction and returns at the edge that takes it.
    // The idle gap ahead of it is drawn fresh for every transaction, except
    // during occasional calm stretches where requests go back to back. When
    // the gap is zero, valid simply stays high, so it is never lowered and
    // raised in the same time step.
    task automatic send_request(input logic [2:0] req, input logic [AMOUNT_WIDTH-1:0] amt,
                                input logic [4:0] h, input logic [5:0] m,
                                input logic [5:0] s, input logic [1:0] fmt);
        int gap;
        if (tx_calm_left > 0) begin
            gap = 0;
            tx_calm_left--;
        end else begin
            gap = $urandom_range(0, 10);
            if ($urandom_range(0, 39) == 0) begin
                tx_calm_left = $urandom_range(20, 60);
            end
        end
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_req_type   <= req;
        i_amount     <= amt;
        i_set_hour   <= h;
        i_set_minute <= m;
        i_set_second <= s;
        i_set_format <= fmt;
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic load_time(input logic [4:0] h, input logic [5:0] m,
                             input logic [5:0] s, input logic [1:0] fmt);
        send_request(REQ_SET, '0, h, m, s, fmt);
    endtask

    task automatic shift_time(input logic [2:0] req, input logic [AMOUNT_WIDTH-1:0] amt);
        send_request(req, amt, '0, '0, '0, FMT_24);
    endtask

    // Holds off new requests until every predicted reading has come back.
    // The first wait makes sure the checker has seen the last transaction.
    task automatic wait_results_drained();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (readings_pending != 0);
    endtask

    // Amounts lean toward small steps and toward multiples of the hour, day
    // and minute lengths, where the carry and borrow chains do their work.
    function automatic logic [AMOUNT_WIDTH-1:0] pick_amount();
        int unsigned span;
        case ($urandom_range(0, 5))
            0: return AMOUNT_WIDTH'($urandom_range(0, 3));
            1: return AMOUNT_WIDTH'($urandom);
            2: return AMOUNT_WIDTH'($urandom_range(0, 5000));
            3: return AMOUNT_WIDTH'($urandom_range(0, 100));
            4: return {AMOUNT_WIDTH{1'b1}} - AMOUNT_WIDTH'($urandom_range(0, 2));
            default: begin
                case ($urandom_range(0, 3))
                    0: span = HOURS_PER_DAY;
                    1: span = MIN_PER_HOUR;
                    2: span = MIN_PER_DAY;
                    default: span = SEC_PER_HOUR;
                endcase
                return AMOUNT_WIDTH'(span * $urandom_range(1, 8) + $urandom_range(0, 2) - 1);
            end
        endcase
    endfunction

    // Draws a random request. Sets are mostly well formed, with minutes and
    // seconds often at the edge of their range so that the next add or
    // subtract rolls over; the rest are fully random fields, which covers
    // bad formats, out-of-range digits and AM hours past noon.
    task automatic send_random_request();
        logic [2:0] req;
        logic [4:0] h;
        logic [5:0] m;
        logic [5:0] s;
        logic [1:0] fmt;
        req = ($urandom_range(0, 99) < 15) ? REQ_SET : 3'($urandom_range(1, 7));
        h   = 5'($urandom);
        m   = 6'($urandom);
        s   = 6'($urandom);
        fmt = 2'($urandom);
        if (req == REQ_SET && $urandom_range(0, 3) != 0) begin
            fmt = 2'($urandom_range(0, 2));
            h   = 5'((fmt == FMT_AM) ? $urandom_range(0, NOON) : $urandom_range(0, MAX_HOUR));
            m   = ($urandom_range(0, 2) == 0) ? 6'(MAX_MINUTE) : 6'($urandom_range(0, MAX_MINUTE));
            s   = ($urandom_range(0, 2) == 0) ? 6'(MAX_SECOND) : 6'($urandom_range(0, MAX_SECOND));
            if ($urandom_range(0, 4) == 0) begin
                h = 5'((fmt == FMT_AM) ? NOON : MAX_HOUR);
            end
        end
        send_request(req, pick_amount(), h, m, s, fmt);
    endtask

    // The result side stalls for a freshly drawn number of cycles ahead of
    // every result transaction, with occasional calm stretches of no stall.
    // Stall is raised only after a result has been taken, never in the step
    // where it was lowered.
    initial begin : result_pacing
        int hold;
        int calm_left;
        calm_left = 0;
        forever begin
            if (calm_left > 0) begin
                hold = 0;
                calm_left--;
            end else begin
                hold = $urandom_range(0, 10);
                if ($urandom_range(0, 39) == 0) begin
                    calm_left = $urandom_range(20, 60);
                end
            end
            if (hold > 0) begin
                i_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
                i_stall <= 1'b0;
            end
            do @(posedge i_clk); while (!o_valid);
        end
    end

    // Watchdog: ends the run if the channels go quiet for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // The reset state, then midnight crossed forward and back by one
        // second, which has to carry and borrow through all three digits.
        shift_time(REQ_READ, '0);
        load_time(5'(MAX_HOUR), 6'(MAX_MINUTE), 6'(MAX_SECOND), FMT_24);
        shift_time(REQ_ADD_SEC, 1);
        shift_time(REQ_SUB_SEC, 1);

        // PM below noon gains twelve hours; noon itself counts as PM, in PM
        // as well as in AM form. PM midnight lands on noon, AM midnight on 0.
        load_time(5'd11, 6'd30, 6'd0, FMT_PM);
        load_time(5'(NOON), 6'd0, 6'd0, FMT_PM);
        load_time(5'(NOON), 6'd0, 6'd0, FMT_AM);
        load_time(5'd0, 6'd0, 6'd0, FMT_PM);
        load_time(5'd0, 6'd0, 6'd0, FMT_AM);

        // Rejected sets: an AM hour past noon, the invalid format, and each
        // digit out of range. Each clears the time but keeps the display mode.
        load_time(5'd13, 6'd15, 6'd15, FMT_AM);
        shift_time(REQ_READ, '0);
        load_time(5'd10, 6'd10, 6'd10, FMT_BAD);
        load_time(5'd31, 6'd0, 6'd0, FMT_24);
        load_time(5'd1, 6'd63, 6'd0, FMT_PM);
        load_time(5'd1, 6'd0, 6'd60, FMT_24);

        // A good 24-hour set clears the error and leaves twelve-hour mode.
        load_time(5'd0, 6'd0, 6'd0, FMT_24);
        shift_time(REQ_SUB_HR, 1);
        shift_time(REQ_ADD_HR, {AMOUNT_WIDTH{1'b1}});
        shift_time(REQ_SUB_HR, {AMOUNT_WIDTH{1'b1}});
        shift_time(REQ_ADD_MIN, {AMOUNT_WIDTH{1'b1}});
        shift_time(REQ_SUB_MIN, '0);
        shift_time(REQ_SUB_MIN, {AMOUNT_WIDTH{1'b1}});
        shift_time(REQ_ADD_SEC, {AMOUNT_WIDTH{1'b1}});
        shift_time(REQ_SUB_SEC, {AMOUNT_WIDTH{1'b1}});

        // Let the pipeline run dry once before the random phase.
        wait_results_drained();

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            send_random_request();
            if (n % 400 == 399) begin
                wait_results_drained();
            end
        end

        wait_results_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
